// ===== design/sitoa_pkg.sv =====
// Shared constants, types and codes for the signed integer to decimal ASCII unit.
package sitoa_pkg;

   localparam int DATA_WIDTH = 32;
   // Decimal digits for a DATA_WIDTH-bit magnitude: floor(W * log10(2)) + 1
   localparam int MAX_DIGITS = (DATA_WIDTH * 1233) / 4096 + 1;
   localparam int BCD_WIDTH = 4 * MAX_DIGITS;
   localparam int BIT_CNT_WIDTH = $clog2(DATA_WIDTH);
   localparam int DIG_CNT_WIDTH = $clog2(MAX_DIGITS);

   localparam logic [BIT_CNT_WIDTH-1:0] LAST_BIT = BIT_CNT_WIDTH'(DATA_WIDTH - 1);
   localparam logic [DIG_CNT_WIDTH-1:0] LAST_DIGIT = DIG_CNT_WIDTH'(MAX_DIGITS - 1);

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } sitoa_state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic emit_sign;
      logic emit_digit;
      logic last_digit;
   } sitoa_cmd_type;

endpackage

// ===== design/signed_int_to_decimal_ascii_unit.sv =====
// Top level: signed integer to decimal ASCII converter, one character word per strobe.
//
//   channel   ports                                    handshake
//   input     req_value                                start && !busy
//   result    rsp_char_code, rsp_last                  rsp_strobe, one cycle, no stall
//
// An accepted word keeps busy high through the conversion and the emission:
// one bit per cycle through the double-dabble shift, then one BCD digit per cycle.
// A new word is taken the cycle busy drops. '-' is flagged in the first shift step and
// registered onto the output; leading zero digits are skipped without a strobe.
// Reset is synchronous and clears the controller and the output strobe.
// The receiver cannot stall: every strobed character is taken in its cycle.
module signed_int_to_decimal_ascii_unit
   import sitoa_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_strobe,
   output logic [7:0]                   rsp_char_code,
   output logic                         rsp_last
);

   sitoa_cmd_type cmd;

   sitoa_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   sitoa_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== design/sitoa_datapath.sv =====
// Datapath: magnitude, double-dabble BCD register and character output register.
module sitoa_datapath
   import sitoa_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  sitoa_cmd_type                cmd,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_strobe,
   output logic [7:0]                   rsp_char_code,
   output logic                         rsp_last
);

   logic [DATA_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_WIDTH-1:0]  bcd_ff, bcd_in;
   logic                  neg_ff, neg_in;
   logic                  started_ff, started_in;
   logic                  strobe_ff, strobe_in;
   logic                  last_ff, last_in;
   logic [7:0]            char_ff, char_in;

   logic [BCD_WIDTH-1:0]  bcd_adj;
   logic [3:0]            top_digit;
   logic                  show_digit;

   // add 3 to every digit of 5 or more ahead of the shift
   always_comb begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   assign top_digit  = bcd_ff[BCD_WIDTH-1 -: 4];
   // suppress leading zeros, but the final digit always goes out
   assign show_digit = started_ff || (top_digit != 4'd0) || cmd.last_digit;

   always_comb begin
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      neg_in     = neg_ff;
      started_in = started_ff;
      strobe_in  = 1'b0;
      last_in    = 1'b0;
      char_in    = char_ff;
      if (cmd.load) begin
         neg_in     = req_value[DATA_WIDTH-1];
         mag_in     = req_value[DATA_WIDTH-1] ? (~req_value + 1'b1) : req_value;
         bcd_in     = '0;
         started_in = 1'b0;
      end
      if (cmd.shift) begin
         bcd_in = {bcd_adj[BCD_WIDTH-2:0], mag_ff[DATA_WIDTH-1]};
         mag_in = {mag_ff[DATA_WIDTH-2:0], 1'b0};
      end
      if (cmd.emit_sign) begin
         strobe_in = neg_ff;
         char_in   = CHAR_MINUS;
      end
      if (cmd.emit_digit) begin
         bcd_in     = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
         started_in = show_digit;
         strobe_in  = show_digit;
         last_in    = cmd.last_digit;
         char_in    = CHAR_ZERO + {4'd0, top_digit};
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      bcd_ff     <= bcd_in;
      neg_ff     <= neg_in;
      started_ff <= started_in;
      char_ff    <= char_in;
      if (reset) begin
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

   a_last_has_strobe: assert property (@(posedge clock) disable iff (reset)
      last_ff |-> strobe_ff)
      else $error("last flag without strobe");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (char_ff == CHAR_MINUS) || ((char_ff >= CHAR_ZERO) && (char_ff <= CHAR_NINE)))
      else $error("illegal character code");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && last_ff) |=> !strobe_ff)
      else $error("strobe right after last character");

endmodule

// ===== design/sitoa_controller.sv =====
// Controller: sequences load, bit-serial conversion and digit emission.
module sitoa_controller
   import sitoa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output sitoa_cmd_type cmd
);

   sitoa_state_type          state_ff, state_in;
   logic [BIT_CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_WIDTH-1:0] dig_cnt_ff, dig_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      cmd        = '0;
      busy       = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load   = 1'b1;
               bit_cnt_in = '0;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift     = 1'b1;
            cmd.emit_sign = (bit_cnt_ff == '0);
            bit_cnt_in    = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == LAST_BIT) begin
               dig_cnt_in = '0;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit_digit = 1'b1;
            cmd.last_digit = (dig_cnt_ff == LAST_DIGIT);
            dig_cnt_in     = dig_cnt_ff + 1'b1;
            if (dig_cnt_ff == LAST_DIGIT) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_CONVERT) && (bit_cnt_ff == '0))
      else $error("accepted word did not start conversion");

   a_convert_to_emit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CONVERT) && (bit_cnt_ff == LAST_BIT))
         |=> (state_ff == ST_EMIT) && (dig_cnt_ff == '0))
      else $error("conversion did not hand over to emission");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without start");

endmodule
